[sv/mbtp_pkg.sv]
// Shared types and constants of the Modbus TCP read-response parser.
`timescale 1ns / 1ps

package mbtp_pkg;

	localparam logic [7:0] FC_READ_HOLDING = 8'd3;
	localparam logic [2:0] HEADER_BYTES    = 3'd6;

	// Header byte positions that carry fields.
	localparam logic [2:0] HDR_TID_HI = 3'd0;
	localparam logic [2:0] HDR_TID_LO = 3'd1;
	localparam logic [2:0] HDR_LEN_HI = 3'd4;
	localparam logic [2:0] HDR_LEN_LO = 3'd5;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_UNIT    = 3'd1,
		PH_FUNC    = 3'd2,
		PH_COUNT   = 3'd3,
		PH_WORD_HI = 3'd4,
		PH_WORD_LO = 3'd5,
		PH_SKIP    = 3'd6
	} phase_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] word_index;
		logic [15:0] word_value;
		logic        frame_done;
		logic        unknown_function;
	} result_t;

endpackage

[sv/mbtp_parse.sv]
// Frame parser state machine: consumes one byte per enable and forms its result.
`timescale 1ns / 1ps

module mbtp_parse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [7:0]           rx_byte,
	output logic                 res_valid,
	output mbtp_pkg::result_t    res
);

	mbtp_pkg::phase_t phase_q, phase_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [15:0] base_q, base_d;
	logic [15:0] len_q, len_d;
	logic [6:0]  words_q, words_d;
	logic [6:0]  offset_q, offset_d;
	logic [7:0]  hi_q, hi_d;
	logic [15:0] skip_q, skip_d;

	logic [2:0]  hdr_inc;
	logic [6:0]  words_dec;
	logic [15:0] skip_dec;
	logic [15:0] skip_init;

	assign hdr_inc   = hdr_cnt_q + 3'd1;
	assign words_dec = words_q - 7'd1;
	assign skip_dec  = skip_q - 16'd1;
	assign skip_init = (len_q > 16'd2) ? (len_q - 16'd2) : 16'd0;

	// Next state.
	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		base_d    = base_q;
		len_d     = len_q;
		words_d   = words_q;
		offset_d  = offset_q;
		hi_d      = hi_q;
		skip_d    = skip_q;
		unique case (phase_q)
			mbtp_pkg::PH_UNIT: begin
				phase_d = mbtp_pkg::PH_FUNC;
			end
			mbtp_pkg::PH_FUNC: begin
				if (rx_byte == mbtp_pkg::FC_READ_HOLDING) begin
					phase_d = mbtp_pkg::PH_COUNT;
				end else begin
					skip_d = skip_init;
					if (skip_init == 16'd0) begin
						phase_d   = mbtp_pkg::PH_HEADER;
						hdr_cnt_d = 3'd0;
					end else begin
						phase_d = mbtp_pkg::PH_SKIP;
					end
				end
			end
			mbtp_pkg::PH_COUNT: begin
				words_d  = rx_byte[7:1];
				offset_d = 7'd0;
				if (rx_byte[7:1] == 7'd0) begin
					phase_d   = mbtp_pkg::PH_HEADER;
					hdr_cnt_d = 3'd0;
				end else begin
					phase_d = mbtp_pkg::PH_WORD_HI;
				end
			end
			mbtp_pkg::PH_WORD_HI: begin
				hi_d    = rx_byte;
				phase_d = mbtp_pkg::PH_WORD_LO;
			end
			mbtp_pkg::PH_WORD_LO: begin
				offset_d = offset_q + 7'd1;
				words_d  = words_dec;
				if (words_dec == 7'd0) begin
					phase_d   = mbtp_pkg::PH_HEADER;
					hdr_cnt_d = 3'd0;
				end else begin
					phase_d = mbtp_pkg::PH_WORD_HI;
				end
			end
			mbtp_pkg::PH_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					phase_d   = mbtp_pkg::PH_HEADER;
					hdr_cnt_d = 3'd0;
				end
			end
			default: begin
				// Header phase; the unused phase code is read the same way.
				phase_d = mbtp_pkg::PH_HEADER;
				unique case (hdr_cnt_q)
					mbtp_pkg::HDR_TID_HI: base_d = {rx_byte, base_q[7:0]};
					mbtp_pkg::HDR_TID_LO: base_d = {base_q[15:8], rx_byte};
					mbtp_pkg::HDR_LEN_HI: len_d  = {rx_byte, len_q[7:0]};
					mbtp_pkg::HDR_LEN_LO: len_d  = {len_q[15:8], rx_byte};
					default: ;
				endcase
				if (hdr_inc >= mbtp_pkg::HEADER_BYTES) begin
					hdr_cnt_d = 3'd0;
					phase_d   = mbtp_pkg::PH_UNIT;
				end else begin
					hdr_cnt_d = hdr_inc;
				end
			end
		endcase
	end

	// Result of the current byte.
	always_comb begin
		res = '0;
		unique case (phase_q)
			mbtp_pkg::PH_FUNC: begin
				if (rx_byte != mbtp_pkg::FC_READ_HOLDING && skip_init == 16'd0) begin
					res.frame_done       = 1'b1;
					res.unknown_function = 1'b1;
				end
			end
			mbtp_pkg::PH_COUNT: begin
				res.frame_done = (rx_byte[7:1] == 7'd0);
			end
			mbtp_pkg::PH_WORD_LO: begin
				res.write_valid = 1'b1;
				res.word_value  = {hi_q, rx_byte};
				res.word_index  = base_q + {9'd0, offset_q};
				res.frame_done  = (words_dec == 7'd0);
			end
			mbtp_pkg::PH_SKIP: begin
				res.frame_done       = (skip_dec == 16'd0);
				res.unknown_function = (skip_dec == 16'd0);
			end
			default: ;
		endcase
	end

	assign res_valid = res.write_valid | res.frame_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mbtp_pkg::PH_HEADER;
			hdr_cnt_q <= 3'd0;
			base_q    <= 16'd0;
			len_q     <= 16'd0;
			words_q   <= 7'd0;
			offset_q  <= 7'd0;
			hi_q      <= 8'd0;
			skip_q    <= 16'd0;
		end else if (en) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			base_q    <= base_d;
			len_q     <= len_d;
			words_q   <= words_d;
			offset_q  <= offset_d;
			hi_q      <= hi_d;
			skip_q    <= skip_d;
		end
	end

endmodule

[sv/modbus_tcp_read_response_parser_core.sv]
// Top level of the Modbus TCP read-holding-registers response parser.
// An accepted byte waits in the input register until the parser consumes it, which
// happens only while the result register has room; its result is then registered there.
// Throughput: one byte per cycle while the output is not stalled with a full result register.
// Bytes that complete neither a word nor a frame produce no output transfer.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to the
// first header byte with all frame state cleared.
`timescale 1ns / 1ps

module modbus_tcp_read_response_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	// Receive byte stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	// Register write and frame status stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] word_index, [31:16] word_value
	output logic [1:0]  m_tuser,   // [0] write_valid, [1] unknown_function
	output logic        m_tlast    // frame_done
);

	// Input register: holds one received byte until the parser may consume it.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register: one pending output transfer.
	logic              out_valid_q;
	mbtp_pkg::result_t out_res_q;

	logic              out_free;
	logic              advance;
	logic              res_valid;
	mbtp_pkg::result_t res;

	// The result register may be loaded when it is empty or its transfer completes now.
	assign out_free = ~out_valid_q | m_tready;
	// The parser consumes the held byte whenever the result register has room, so a new
	// byte can be taken every cycle while the output keeps pace.
	assign advance  = valid_s1 & out_free;
	assign s_tready = ~valid_s1 | out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	mbtp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance & res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.word_value, out_res_q.word_index};
	assign m_tuser  = {out_res_q.unknown_function, out_res_q.write_valid};
	assign m_tlast  = out_res_q.frame_done;

endmodule

[sv/mbtp_checker.sv]
// Port-level assertions for the response parser, bound to its top level.
`timescale 1ns / 1ps

module mbtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// Every output transfer carries a word write or an end of frame.
	a_has_content: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser[0] || m_tlast))
		else $error("output transfer with neither write nor frame end");

	// An unknown function is only reported on the last byte of its frame.
	a_unknown_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0]))
		else $error("unknown function flag without frame end or with a write");

	// Status-only transfers carry zero index and value.
	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
		else $error("non-write transfer carries data");

	// A stalled output transfer holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast)))
		else $error("stalled output transfer changed");

endmodule

bind modbus_tcp_read_response_parser_core mbtp_checker u_mbtp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

[tb/tb_modbus_tcp_read_response_parser_core.sv]
// Self-checking testbench for the Modbus TCP read-response parser core.
`timescale 1ns / 1ps

module tb_modbus_tcp_read_response_parser_core;

	import mbtp_pkg::*;

	localparam int      WATCHDOG_LIMIT = 5000;
	localparam int      HOLD_CYCLES    = 300;
	localparam int      SETTLE_CYCLES  = 8;
	localparam int      PHASE_BYTES    = 212;
	localparam result_t NO_RESULT      = '0;

	typedef enum logic {
		CHECK_BY_MODEL,
		CHECK_GIVEN
	} row_check_t;

	typedef struct packed {
		logic [7:0] rx;
		row_check_t chk;
		result_t    res;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;    // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;            // [15:0] word_index, [31:16] word_value
	logic [1:0]  m_tuser;            // [0] write_valid, [1] unknown_function
	logic        m_tlast;            // frame_done

	// Parser state as the checker sees it, updated once per accepted byte.
	phase_t      cur_phase   = PH_HEADER;
	logic [2:0]  hdr_pos     = 3'd0;
	logic [15:0] txn_base    = 16'h0000;
	logic [15:0] frame_len   = 16'h0000;
	logic [6:0]  words_to_go = 7'd0;
	logic [6:0]  word_pos    = 7'd0;
	logic [7:0]  word_hi     = 8'h00;
	logic [15:0] skip_to_go  = 16'h0000;

	result_t     expected_q [$];
	int          mismatch_count = 0;
	int          bytes_sent     = 0;
	int          idle_cycles    = 0;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          hold_requested = 0;
	int          hold_served    = 0;
	int          hold_left      = 0;

	int          send_idle_tab [4]  = '{0, 63, 0, 17};
	int          recv_stall_tab [4] = '{0, 0, 63, 17};

	// Three short frames: a one-word read at the top of the index range whose odd
	// count leaves a byte for the next header, an unknown function with nothing to
	// skip, and a read whose count is too small to hold a word.
	directed_row_t directed_rows [28] = '{
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'h03, CHECK_BY_MODEL, NO_RESULT},
		'{8'h03, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_GIVEN, result_t'{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}},
		'{8'h80, CHECK_BY_MODEL, NO_RESULT},
		'{8'h01, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'h02, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_GIVEN, result_t'{1'b0, 16'h0000, 16'h0000, 1'b1, 1'b1}},
		'{8'h5A, CHECK_BY_MODEL, NO_RESULT},
		'{8'hA5, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'h00, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'hFF, CHECK_BY_MODEL, NO_RESULT},
		'{8'h01, CHECK_BY_MODEL, NO_RESULT},
		'{8'h03, CHECK_BY_MODEL, NO_RESULT},
		'{8'h01, CHECK_GIVEN, result_t'{1'b0, 16'h0000, 16'h0000, 1'b1, 1'b0}}
	};

	modbus_tcp_read_response_parser_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advances the parser state by one byte and reports the write or frame status
	// that byte should produce, if any.
	task automatic parse_rx_byte(input logic [7:0] b, output bit produced, output result_t res);
		res = NO_RESULT;
		case (cur_phase)
			PH_UNIT: begin
				cur_phase = PH_FUNC;
			end
			PH_FUNC: begin
				if (b == FC_READ_HOLDING) begin
					cur_phase = PH_COUNT;
				end else begin
					skip_to_go = (frame_len > 16'd2) ? frame_len - 16'd2 : 16'd0;
					if (skip_to_go == 16'd0) begin
						res.frame_done       = 1'b1;
						res.unknown_function = 1'b1;
						cur_phase            = PH_HEADER;
						hdr_pos              = 3'd0;
					end else begin
						cur_phase = PH_SKIP;
					end
				end
			end
			PH_COUNT: begin
				words_to_go = b[7:1];
				word_pos    = 7'd0;
				if (words_to_go == 7'd0) begin
					res.frame_done = 1'b1;
					cur_phase      = PH_HEADER;
					hdr_pos        = 3'd0;
				end else begin
					cur_phase = PH_WORD_HI;
				end
			end
			PH_WORD_HI: begin
				word_hi   = b;
				cur_phase = PH_WORD_LO;
			end
			PH_WORD_LO: begin
				res.write_valid = 1'b1;
				res.word_value  = {word_hi, b};
				res.word_index  = txn_base + {9'd0, word_pos};
				word_pos        = word_pos + 7'd1;
				words_to_go     = words_to_go - 7'd1;
				if (words_to_go == 7'd0) begin
					res.frame_done = 1'b1;
					cur_phase      = PH_HEADER;
					hdr_pos        = 3'd0;
				end else begin
					cur_phase = PH_WORD_HI;
				end
			end
			PH_SKIP: begin
				skip_to_go = skip_to_go - 16'd1;
				if (skip_to_go == 16'd0) begin
					res.frame_done       = 1'b1;
					res.unknown_function = 1'b1;
					cur_phase            = PH_HEADER;
					hdr_pos              = 3'd0;
				end
			end
			default: begin
				cur_phase = PH_HEADER;
				case (hdr_pos)
					HDR_TID_HI: txn_base[15:8]  = b;
					HDR_TID_LO: txn_base[7:0]   = b;
					HDR_LEN_HI: frame_len[15:8] = b;
					HDR_LEN_LO: frame_len[7:0]  = b;
					default: ;
				endcase
				hdr_pos = hdr_pos + 3'd1;
				if (hdr_pos >= HEADER_BYTES) begin
					hdr_pos   = 3'd0;
					cur_phase = PH_UNIT;
				end
			end
		endcase
		produced = res.write_valid || res.frame_done;
	endtask

	// Offers one byte after a random idle stretch and waits for its transfer. The
	// expectation comes from the table when one is given there, else from the parser.
	task automatic push_byte(input logic [7:0] b, input row_check_t chk, input result_t given_res);
		bit      produced;
		result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		parse_rx_byte(b, produced, predicted);
		if (chk == CHECK_GIVEN) begin
			expected_q.push_back(given_res);
		end else if (produced) begin
			expected_q.push_back(predicted);
		end
		bytes_sent++;
	endtask

	// Sends one frame with random content. Header bytes that an odd byte count has
	// already supplied are left out, so frames stay aligned with the parser.
	task automatic send_frame(input bit long_read);
		logic [7:0]  hdr [6];
		logic [15:0] len;
		logic [7:0]  func;
		logic [7:0]  count;
		int          first;
		int          n;
		int          r;
		first  = int'(hdr_pos);
		hdr[0] = ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom_range(255));
		hdr[1] = 8'($urandom_range(255));
		hdr[2] = 8'($urandom_range(255));
		hdr[3] = 8'($urandom_range(255));
		r      = $urandom_range(99);
		func   = FC_READ_HOLDING;
		if (long_read || r < 70) begin
			// The length field does not bound a read, so it is left random.
			len = 16'($urandom);
		end else begin
			func = 8'($urandom_range(255));
			if (func == FC_READ_HOLDING) begin
				func = 8'h83;
			end
			r = $urandom_range(99);
			if (r < 25) begin
				len = 16'($urandom_range(2));
			end else if (r < 30) begin
				len = 16'($urandom_range(300, 100));
			end else begin
				len = 16'($urandom_range(12, 3));
			end
		end
		hdr[4] = len[15:8];
		hdr[5] = len[7:0];
		for (int i = first; i < 6; i++) begin
			push_byte(hdr[i], CHECK_BY_MODEL, NO_RESULT);
		end
		push_byte(8'($urandom_range(255)), CHECK_BY_MODEL, NO_RESULT);
		push_byte(func, CHECK_BY_MODEL, NO_RESULT);
		if (func == FC_READ_HOLDING) begin
			r = $urandom_range(99);
			if (long_read) begin
				count = 8'd64;
			end else if (r < 3) begin
				count = ($urandom_range(1) == 0) ? 8'hFF : 8'hFE;
			end else if (r < 12) begin
				count = 8'($urandom_range(1));
			end else begin
				count = 8'($urandom_range(24, 2));
			end
			push_byte(count, CHECK_BY_MODEL, NO_RESULT);
			n = 2 * int'(count[7:1]);
			// An odd count leaves one byte over; it opens the next header.
			if (count[0]) begin
				n++;
			end
		end else begin
			n = (len > 16'd2) ? int'(len) - 2 : 0;
		end
		for (int i = 0; i < n; i++) begin
			push_byte(8'($urandom_range(255)), CHECK_BY_MODEL, NO_RESULT);
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
	always @(posedge clk) begin
		if (hold_served != hold_requested) begin
			hold_served <= hold_requested;
			hold_left   <= HOLD_CYCLES;
			m_tready    <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Each output transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_q.size() == 0) begin
				$error("output transfer with nothing expected: tdata %h tuser %b tlast %b",
					m_tdata, m_tuser, m_tlast);
				mismatch_count++;
			end else begin
				want = expected_q.pop_front();
				check_field("write_valid", 16'(want.write_valid), 16'(m_tuser[0]));
				check_field("word_index", want.word_index, m_tdata[15:0]);
				check_field("word_value", want.word_value, m_tdata[31:16]);
				check_field("frame_done", 16'(want.frame_done), 16'(m_tlast));
				check_field("unknown_function", 16'(want.unknown_function), 16'(m_tuser[1]));
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int phase_start;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			push_byte(directed_rows[i].rx, directed_rows[i].chk, directed_rows[i].res);
		end
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_q.size() != 0);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = send_idle_tab[ph];
			recv_stall_pct <= recv_stall_tab[ph];
			phase_start    = bytes_sent;
			if (ph == 0) begin
				// Hold the receiver off while a long read keeps arriving, so the core
				// fills up and has to refuse input.
				hold_requested <= hold_requested + 1;
				send_frame(1'b1);
			end
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				send_frame(1'b0);
			end
			// The sender pauses until every expected transfer has arrived.
			s_tvalid <= 1'b0;
			do @(posedge clk); while (expected_q.size() != 0);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
